// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication under an active-low reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/rfcm_pkg.sv =====
// Shared types, constants and helpers for the RFID frame check and match block.
// No dependencies.
package rfcm_pkg;

    // Framing bytes
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;

    // Write position: 4 bits, wraps after slot 14
    localparam int unsigned POS_W      = 4;
    localparam int unsigned WRAP_AFTER = 14;

    // Parameter defaults
    localparam int unsigned FRAME_SLOTS_DEF = 15;
    localparam int unsigned ID_BYTES_DEF    = 5;
    localparam int unsigned NUM_CARDS_DEF   = 4;

    // Fixed field widths
    localparam int unsigned MAX_CARDS    = 4;
    localparam int unsigned CARD_ID_W    = 40;
    localparam int unsigned CARD_IDX_W   = 2;
    localparam int unsigned CARD_COUNT_W = 3;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CARD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARD_ID0   = 3'd1;

    // Reset values of the registers
    localparam logic [CARD_COUNT_W-1:0] CARD_COUNT_RST = 3'd4;
    localparam logic [CARD_ID_W-1:0] CARD_ID_RST [MAX_CARDS] = '{
        40'h07_0054_37A9, 40'h07_0054_37A7, 40'h07_0054_37A5, 40'h07_0054_37A3
    };

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_MATCH = 4'b1000
    } t_state;

    // Uppercase hex character to nibble; anything else is zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end
            return d[3:0];
        end
    endfunction

endpackage

// ===== hw/rtl/rfcm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rfcm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rfid_frame_check_and_match.sv =====
// RFID frame check and match: top level. Uses rfcm_pkg, rfcm_ram, assert_macros.svh.
// Input: an ordinary byte is accepted with no stall while idle; an ETX that closes a
// frame holds the input while slots 1..2*ID_BYTES+2 are read one per cycle through the
// single read port of the frame RAM, and then through the drain and match states.
// The result is registered in the match state once the output register is free.
// Reset (sync, active low): idle, position 0, slot valid bits cleared (buffer reads 0).
`include "assert_macros.svh"

module rfid_frame_check_and_match #(
    parameter int unsigned FRAME_SLOTS = rfcm_pkg::FRAME_SLOTS_DEF,
    parameter int unsigned ID_BYTES    = rfcm_pkg::ID_BYTES_DEF,
    parameter int unsigned NUM_CARDS   = rfcm_pkg::NUM_CARDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [rfcm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rfcm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_rx_byte,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_checksum_ok,
    output logic                                o_card_found,
    output logic [rfcm_pkg::CARD_IDX_W-1:0]     o_card_index,
    output logic [rfcm_pkg::CARD_ID_W-1:0]      o_card_id
);
    import rfcm_pkg::*;

    localparam int unsigned AW        = $clog2(FRAME_SLOTS);
    localparam int unsigned ID_W      = 8 * ID_BYTES;
    localparam int unsigned ID_SLOTS  = 2 * ID_BYTES;
    localparam logic [AW-1:0] LAST_SLOT = AW'(ID_SLOTS + 2);
    localparam logic [AW-1:0] SUM_HI    = AW'(ID_SLOTS + 1);

    // Configuration registers
    logic [CARD_COUNT_W-1:0] r_card_count;
    logic [CARD_ID_W-1:0]    r_card_id [NUM_CARDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_count <= CARD_COUNT_RST;
            for (int k = 0; k < NUM_CARDS; k++) begin
                r_card_id[k] <= CARD_ID_RST[k];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_CARD_COUNT) begin
                r_card_count <= i_cfg_wdata[CARD_COUNT_W-1:0];
            end
            for (int k = 0; k < NUM_CARDS; k++) begin
                if (i_cfg_idx == REG_CARD_ID0 + CFG_IDX_W'(k)) begin
                    r_card_id[k] <= i_cfg_wdata[CARD_ID_W-1:0];
                end
            end
        end
    end

    // Control state
    t_state                r_state;
    logic                  r_capturing;
    logic [POS_W-1:0]      r_wpos;
    logic [FRAME_SLOTS-1:0] r_slot_vld;
    logic [AW-1:0]         r_slot;
    logic                  r_dvld;
    logic [AW-1:0]         r_dslot;
    logic                  r_dslot_vld;

    // Accumulators
    logic [ID_W-1:0]       r_id;
    logic [3:0]            r_xhi, r_xlo, r_rhi, r_rlo;

    // Output register
    logic                  r_ovld;
    logic                  r_out_ok;
    logic                  r_out_found;
    logic [CARD_IDX_W-1:0] r_out_index;
    logic [CARD_ID_W-1:0]  r_out_id;

    // Input transaction and capture position
    logic             in_acc;
    logic             is_stx;
    logic             cap_now;
    logic [POS_W-1:0] pos_base;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] n_wpos;
    logic             wr_en;
    logic             emit;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign is_stx  = (i_rx_byte == BYTE_STX);
    assign cap_now = r_capturing || is_stx;
    assign pos_base = is_stx ? '0 : r_wpos;
    assign pos_inc  = pos_base + POS_W'(1);

    always_comb begin
        n_wpos = r_wpos;
        if (cap_now) begin
            n_wpos = pos_inc;
            if (32'(pos_inc) > WRAP_AFTER || 32'(pos_inc) >= FRAME_SLOTS) begin
                n_wpos = '0;
            end
        end
    end

    assign wr_en = in_acc && cap_now && (32'(pos_base) < FRAME_SLOTS);
    assign emit  = in_acc && (i_rx_byte == BYTE_ETX) && (n_wpos != '0);

    // Frame buffer
    logic [7:0] ram_q;
    logic [3:0] nib;

    rfcm_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_SLOTS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (pos_base[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_slot),
        .o_rdata (ram_q)
    );

    // Unwritten slots read as zero
    assign nib = r_dslot_vld ? hex_value(ram_q) : 4'h0;

    // Card match over the compared ids; lowest index wins
    logic                  match_found;
    logic [CARD_IDX_W-1:0] match_index;
    logic [CARD_ID_W-1:0]  id_ext;
    logic                  out_free;

    assign id_ext   = CARD_ID_W'(r_id);
    assign out_free = !r_ovld || !i_stall;

    always_comb begin
        match_found = 1'b0;
        match_index = '0;
        for (int k = NUM_CARDS - 1; k >= 0; k--) begin
            if (32'(r_card_count) > k && r_card_id[k] == id_ext) begin
                match_found = 1'b1;
                match_index = CARD_IDX_W'(k);
            end
        end
    end

    // Capture state, valid bits and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capturing <= 1'b0;
            r_wpos      <= '0;
            r_slot_vld  <= '0;
            r_slot      <= '0;
            r_dvld      <= 1'b0;
        end else begin
            r_dvld <= (r_state == S_READ);
            if (wr_en) begin
                r_slot_vld[pos_base[AW-1:0]] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_wpos      <= n_wpos;
                        r_capturing <= emit ? 1'b0 : cap_now;
                        if (emit) begin
                            r_slot  <= AW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_slot == LAST_SLOT) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_slot <= r_slot + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_MATCH;
                end
                S_MATCH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Read pipeline tags
    always_ff @(posedge i_clk) begin
        r_dslot     <= r_slot;
        r_dslot_vld <= r_slot_vld[r_slot];
    end

    // Id and checksum accumulation
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_id  <= '0;
            r_xhi <= 4'h0;
            r_xlo <= 4'h0;
        end else if (r_dvld) begin
            if (32'(r_dslot) <= ID_SLOTS) begin
                r_id <= {r_id[ID_W-5:0], nib};
                if (r_dslot[0]) begin
                    r_xhi <= r_xhi ^ nib;
                end else begin
                    r_xlo <= r_xlo ^ nib;
                end
            end else if (r_dslot == SUM_HI) begin
                r_rhi <= nib;
            end else begin
                r_rlo <= nib;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (r_state == S_MATCH && out_free) begin
            r_ovld <= 1'b1;
        end else if (r_ovld && !i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MATCH && out_free) begin
            r_out_ok    <= ({r_xhi, r_xlo} == {r_rhi, r_rlo}) && ({r_rhi, r_rlo} != 8'h00);
            r_out_found <= match_found;
            r_out_index <= match_index;
            r_out_id    <= id_ext;
        end
    end

    assign o_valid       = r_ovld;
    assign o_checksum_ok = r_out_ok;
    assign o_card_found  = r_out_found;
    assign o_card_index  = r_out_index;
    assign o_card_id     = r_out_id;

    // Checks
    `AST_NEXT(a_emit_starts_read, i_clk, i_rst_n, emit, r_state == S_READ && r_slot == AW'(1))
    `AST_IMPLY(a_slot_range, i_clk, i_rst_n, r_state == S_READ, r_slot != '0 && r_slot <= LAST_SLOT)
    `AST_IMPLY(a_wpos_range, i_clk, i_rst_n, 1'b1, 32'(r_wpos) <= WRAP_AFTER && 32'(r_wpos) < FRAME_SLOTS)
    `AST_NEXT(a_match_loads, i_clk, i_rst_n, r_state == S_MATCH && !r_ovld, r_ovld && r_state == S_IDLE)

endmodule

// ===== verif/rfid_frame_check_and_match_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rfid_frame_check_and_match: feeds reader bytes, predicts
// frame decode, checksum and card match, and compares every result. Needs rfcm_pkg.
module rfid_frame_check_and_match_tb;
    import rfcm_pkg::*;

    localparam int IDLE_PCT        = 13;
    localparam int DRAIN_CYCLES    = 2 * (2 * ID_BYTES_DEF + 4);
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_BYTES     = 290;
    // first register index past the card ids; writes there are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_CARD_ID0 + MAX_CARDS);

    typedef struct packed {
        logic                  checksum_ok;
        logic                  card_found;
        logic [CARD_IDX_W-1:0] card_index;
        logic [CARD_ID_W-1:0]  card_id;
    } t_match;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [7:0]              i_rx_byte = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_checksum_ok;
    logic                    o_card_found;
    logic [CARD_IDX_W-1:0]   o_card_index;
    logic [CARD_ID_W-1:0]    o_card_id;

    // predictor state
    logic                    cap_active;
    logic [POS_W-1:0]        cap_pos;
    logic [7:0]              frame_slots [FRAME_SLOTS_DEF];
    logic [CARD_COUNT_W-1:0] cmp_count;
    logic [CARD_ID_W-1:0]    known_ids [MAX_CARDS];

    logic [7:0] byte_queue [$];
    t_match     match_queue [$];
    int         bytes_in_flight = 0;
    int         bytes_pushed = 0;
    int         err_count = 0;
    bit         idle_on = 1'b1;
    bit         hold_go = 1'b0;
    logic       hold_off = 1'b0;

    rfid_frame_check_and_match dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_checksum_ok (o_checksum_ok),
        .o_card_found  (o_card_found),
        .o_card_index  (o_card_index),
        .o_card_id     (o_card_id)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ASCII uppercase hex digit to nibble; any other byte gives zero
    function automatic logic [3:0] ascii_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c[3:0];
        if (c >= "A" && c <= "F") return c[3:0] + 4'd9;
        return 4'h0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        // digits start at 0x30, letters at 0x41 (0x37 + 10)
        return 8'(v) + ((v < 4'd10) ? 8'h30 : 8'h37);
    endfunction

    function automatic logic [7:0] id_checksum(input logic [CARD_ID_W-1:0] id);
        return id[39:32] ^ id[31:24] ^ id[23:16] ^ id[15:8] ^ id[7:0];
    endfunction

    function automatic logic [7:0] slot_byte(input int first);
        return {ascii_nibble(frame_slots[first]), ascii_nibble(frame_slots[first + 1])};
    endfunction

    function automatic void reset_model();
        int k;
        cap_active = 1'b0;
        cap_pos    = '0;
        for (k = 0; k < FRAME_SLOTS_DEF; k++) frame_slots[k] = 8'h00;
        cmp_count = CARD_COUNT_RST;
        for (k = 0; k < MAX_CARDS; k++) known_ids[k] = CARD_ID_RST[k];
    endfunction

    // Capture one byte; returns 1 with the decoded frame when it closes one
    function automatic bit frame_byte(input logic [7:0] b, output t_match r);
        logic [7:0] id_byte;
        logic [7:0] xsum;
        logic [7:0] rsum;
        int         n;
        int         limit;
        r = '0;
        if (b == BYTE_STX) begin
            cap_pos    = '0;
            cap_active = 1'b1;
        end
        if (cap_active) begin
            if (cap_pos < FRAME_SLOTS_DEF) frame_slots[cap_pos] = b;
            cap_pos = cap_pos + 1'b1;
            if (cap_pos > WRAP_AFTER || cap_pos >= FRAME_SLOTS_DEF) cap_pos = '0;
        end
        // ETX that leaves the position at zero closes nothing
        if (b != BYTE_ETX || cap_pos == '0) return 1'b0;
        cap_active = 1'b0;
        xsum = 8'h00;
        for (n = 0; n < ID_BYTES_DEF; n++) begin
            id_byte   = slot_byte(2 * n + 1);
            r.card_id = {r.card_id[CARD_ID_W-9:0], id_byte};
            xsum      = xsum ^ id_byte;
        end
        rsum = slot_byte(2 * ID_BYTES_DEF + 1);
        r.checksum_ok = (rsum == xsum) && (rsum != 8'h00);
        limit = (cmp_count > NUM_CARDS_DEF) ? NUM_CARDS_DEF : cmp_count;
        for (n = 0; n < limit; n++) begin
            if (!r.card_found && known_ids[n] == r.card_id) begin
                r.card_found = 1'b1;
                r.card_index = n[CARD_IDX_W-1:0];
            end
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endfunction

    // Byte driver: predicts on each accepted transaction, then offers the next byte
    always @(posedge i_clk) begin : byte_driver
        t_match m;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (frame_byte(i_rx_byte, m)) match_queue.push_back(m);
                bytes_in_flight--;
            end
            if (!i_valid || !o_stall) begin
                if (byte_queue.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
                    i_valid   <= 1'b1;
                    i_rx_byte <= byte_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge i_clk) begin : match_monitor
        t_match want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (match_queue.size() == 0) begin
                    $error("unexpected result: card_id %h", o_card_id);
                    err_count++;
                end else begin
                    want = match_queue.pop_front();
                    check_field("checksum_ok", want.checksum_ok, o_checksum_ok);
                    check_field("card_found", want.card_found, o_card_found);
                    check_field("card_index", want.card_index, o_card_index);
                    check_field("card_id", want.card_id, o_card_id);
                end
            end
            i_stall <= hold_off || (idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Long receiver hold-off so the block backs up into its input
    initial begin : hold_off_ctl
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void push_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_in_flight++;
        bytes_pushed++;
    endfunction

    // STX, id as ten hex characters, two checksum characters, filler, ETX
    function automatic void queue_frame(input logic [CARD_ID_W-1:0] id, input logic [7:0] csum,
                                        input int filler, input bit garble);
        logic [7:0] body [12];
        int         k;
        for (k = 0; k < 10; k++) body[k] = hex_char(id[36 - 4 * k +: 4]);
        body[10] = hex_char(csum[7:4]);
        body[11] = hex_char(csum[3:0]);
        if (garble) body[$urandom_range(11)] = 8'($urandom_range(255));
        push_byte(BYTE_STX);
        for (k = 0; k < 12; k++) push_byte(body[k]);
        repeat (filler) push_byte(8'($urandom_range(8'h20, 8'h7E)));
        push_byte(BYTE_ETX);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CARD_COUNT) cmp_count = data[CARD_COUNT_W-1:0];
        else if (idx >= REG_CARD_ID0 && idx < REG_SPARE)
            known_ids[CARD_IDX_W'(idx - REG_CARD_ID0)] = data;
    endtask

    task automatic wait_idle();
        while (bytes_in_flight != 0 || match_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random ids, plus bad checksums, garbled text,
    // wrapping frames, truncated frames, stray ETX and line noise
    task automatic random_phase(input int nbytes);
        int                   start;
        int                   pick;
        int                   k;
        logic [CARD_ID_W-1:0] id;
        start = bytes_pushed;
        while (bytes_pushed - start < nbytes) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                id = known_ids[$urandom_range(MAX_CARDS - 1)];
            end else if (pick < 50) begin
                case ($urandom_range(2))
                    0: id = '0;
                    1: id = '1;
                    default: begin
                        id       = {8'($urandom), $urandom};
                        id[7:0]  = 8'h00;
                        id[7:0]  = id_checksum(id);
                    end
                endcase
            end else begin
                id = {8'($urandom), $urandom};
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                queue_frame(id, id_checksum(id), 0, 1'b0);
            end else if (pick < 78) begin
                queue_frame(id, id_checksum(id) ^ 8'($urandom_range(1, 255)), 0, 1'b0);
            end else if (pick < 84) begin
                queue_frame(id, id_checksum(id), 0, 1'b1);
            end else if (pick < 88) begin
                queue_frame(id, id_checksum(id), $urandom_range(1, 3), 1'b0);
            end else if (pick < 92) begin
                push_byte(BYTE_STX);
                repeat ($urandom_range(12)) push_byte(hex_char(4'($urandom_range(15))));
                push_byte(BYTE_ETX);
            end else if (pick < 95) begin
                push_byte(BYTE_ETX);
            end else begin
                for (k = $urandom_range(1, 6); k > 0; k--) push_byte(8'($urandom_range(255)));
            end
        end
        wait_idle();
    endtask

    initial begin : stimulus
        int k;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: card 0 after reset, repeated ETX while idle, non-hex and extreme bytes
        queue_frame(CARD_ID_RST[0], id_checksum(CARD_ID_RST[0]), 0, 1'b0);
        push_byte(BYTE_ETX);
        push_byte(BYTE_STX);
        push_byte("z");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(BYTE_ETX);
        wait_idle();

        // All registers, extreme ids, ignored indexes; receiver hold-off in this phase
        write_reg(REG_CARD_COUNT, CFG_DATA_W'(3));
        write_reg(REG_CARD_ID0, '1);
        write_reg(CFG_IDX_W'(REG_CARD_ID0 + 1), '0);
        write_reg(CFG_IDX_W'(REG_CARD_ID0 + 2), {8'($urandom), $urandom});
        write_reg(CFG_IDX_W'(REG_CARD_ID0 + 3), {8'($urandom), $urandom});
        for (k = REG_SPARE; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), {8'($urandom), $urandom});
        hold_go = 1'b1;
        random_phase(PHASE_BYTES);

        // No cards compared; no idling on either side
        idle_on = 1'b0;
        write_reg(REG_CARD_COUNT, CFG_DATA_W'(0));
        random_phase(PHASE_BYTES);
        idle_on = 1'b1;

        // Count above the number of cards, duplicate ids so the lowest index wins
        write_reg(REG_CARD_COUNT, CFG_DATA_W'(7));
        write_reg(CFG_IDX_W'(REG_CARD_ID0 + 1), {8'($urandom), $urandom});
        write_reg(CFG_IDX_W'(REG_CARD_ID0 + 2), known_ids[1]);
        random_phase(PHASE_BYTES);

        write_reg(REG_CARD_COUNT, CFG_DATA_W'(1));
        write_reg(REG_CARD_ID0, {8'($urandom), $urandom});
        random_phase(PHASE_BYTES);

        write_reg(REG_CARD_COUNT, CFG_DATA_W'(2));
        write_reg(CFG_IDX_W'(REG_CARD_ID0 + 3), known_ids[0]);
        random_phase(PHASE_BYTES);

        write_reg(REG_CARD_COUNT, CFG_DATA_W'(5));
        write_reg(CFG_IDX_W'(REG_CARD_ID0 + 3), {8'($urandom), $urandom});
        random_phase(PHASE_BYTES);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rfcm_pkg.sv
hw/rtl/rfcm_ram.sv
hw/rtl/rfid_frame_check_and_match.sv
verif/rfid_frame_check_and_match_tb.sv
